// ===== rtl/two_class_weighted_ticket_queue_unit_macros.svh =====
// assertion helpers for the ticket queue unit
`ifndef TWO_CLASS_WEIGHTED_TICKET_QUEUE_UNIT_MACROS_SVH
`define TWO_CLASS_WEIGHTED_TICKET_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define TWTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define TWTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/twtq_pkg.sv =====
package twtq_pkg;

	localparam int TICKET_W  = 14;
	localparam int SHARE_W   = 4;
	localparam int COUNT_W   = 5;
	localparam int OPQ_DEPTH = 2;

	localparam logic [SHARE_W-1:0] SHARE_RESET = 4'd7;

	// register map, word index taken from paddr[2]
	localparam logic REG_SHARE = 1'b0;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                prio;
		logic [TICKET_W-1:0] ticket;
	} cell_t;

	// classified command handed from front to back
	typedef struct packed {
		cmd_t                cmd;
		logic [TICKET_W-1:0] ticket;
		logic                prio;
		logic                want;
	} op_t;

	typedef struct packed {
		status_t             status;
		logic [TICKET_W-1:0] ticket;
		logic                prio;
		logic [COUNT_W-1:0]  count;
		logic                empty;
		logic                full;
	} result_t;

endpackage

// ===== rtl/twtq_front.sv =====
module twtq_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      cmd,
	input  logic [twtq_pkg::TICKET_W-1:0]   ticket_number,
	input  logic                            is_priority,
	input  logic [3:0]                      random_draw,
	input  logic [twtq_pkg::SHARE_W-1:0]    share,
	output twtq_pkg::op_t                   op,
	output logic                            op_valid,
	input  logic                            op_ready
);
	import twtq_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	logic take;

	assign take = push && !full;
	assign full = valid_s1 && !op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// class choice made here, ahead of the cell chain
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1.cmd    <= cmd_t'(cmd);
			op_s1.ticket <= ticket_number;
			op_s1.prio   <= is_priority;
			op_s1.want   <= (random_draw < share);
		end
	end

	assign op       = op_s1;
	assign op_valid = valid_s1;

endmodule

// ===== rtl/twtq_opq.sv =====
module twtq_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  twtq_pkg::op_t in_op,
	input  logic          in_valid,
	output logic          in_ready,
	output twtq_pkg::op_t out_op,
	output logic          out_valid,
	input  logic          out_ready
);
	import twtq_pkg::*;

	localparam int PW = $clog2(OPQ_DEPTH);

	op_t           slot_q [OPQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   fill_q;
	logic          wr_en;
	logic          rd_en;

	assign in_ready  = (fill_q != (PW+1)'(OPQ_DEPTH));
	assign out_valid = (fill_q != '0);
	assign wr_en     = in_valid && in_ready;
	assign rd_en     = out_valid && out_ready;
	assign out_op    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= in_op;
		end
	end

endmodule

// ===== rtl/twtq_back.sv =====
module twtq_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  twtq_pkg::op_t     op,
	input  logic              op_valid,
	output logic              op_ready,
	output twtq_pkg::result_t res,
	output logic              res_valid,
	input  logic              res_pop
);
	import twtq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cell_t               cell_q [QUEUE_DEPTH];
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nx;
	result_t             res_q;
	result_t             res_nx;
	logic                res_valid_q;
	logic                do_op;
	logic                is_full;
	logic                is_empty;
	logic                ins_ok;
	logic                rem_ok;
	logic [QUEUE_DEPTH-1:0] match;
	logic [QUEUE_DEPTH-1:0] first;
	logic [QUEUE_DEPTH-1:0] sel;
	logic [QUEUE_DEPTH-1:0] shift;
	cell_t               picked;
	logic [CW+COUNT_W-1:0] count_ext;

	assign op_ready = !res_valid_q || res_pop;
	assign do_op    = op_valid && op_ready;
	assign is_full  = (count_q == CW'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	// per-cell class match, oldest one wins
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			match[i] = (CW'(i) < count_q) && (cell_q[i].prio == op.want);
		end
	end

	assign first = match & (~match + 1'b1);
	assign sel   = (match == '0) ? QUEUE_DEPTH'(1) : first;

	// cells at and after the chosen one take their neighbour
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			shift[i] = |(sel & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
		end
	end

	always_comb begin
		picked = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			picked = picked | (sel[i] ? cell_q[i] : cell_t'('0));
		end
	end

	always_comb begin
		ins_ok        = 1'b0;
		rem_ok        = 1'b0;
		count_nx      = count_q;
		res_nx.status = ST_DONE;
		res_nx.ticket = '0;
		res_nx.prio   = 1'b0;
		unique case (op.cmd)
			CMD_INSERT: begin
				if (is_full) begin
					res_nx.status = ST_FULL;
				end else begin
					ins_ok   = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (is_empty) begin
					res_nx.status = ST_EMPTY;
				end else begin
					rem_ok        = 1'b1;
					count_nx      = count_q - 1'b1;
					res_nx.ticket = picked.ticket;
					res_nx.prio   = picked.prio;
				end
			end
			CMD_CLEAR: begin
				count_nx = '0;
			end
			default: begin
				count_nx = count_q;
			end
		endcase
		count_ext    = {{COUNT_W{1'b0}}, count_nx};
		res_nx.count = count_ext[COUNT_W-1:0];
		res_nx.empty = (count_nx == '0);
		res_nx.full  = (count_nx == CW'(QUEUE_DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_op) begin
				count_q     <= count_nx;
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_op) begin
			res_q <= res_nx;
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g < QUEUE_DEPTH - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (do_op && ins_ok && (CW'(g) == count_q)) begin
					cell_q[g] <= '{prio: op.prio, ticket: op.ticket};
				end else if (do_op && rem_ok && shift[g]) begin
					cell_q[g] <= cell_q[g+1];
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (do_op && ins_ok && (CW'(g) == count_q)) begin
					cell_q[g] <= '{prio: op.prio, ticket: op.ticket};
				end
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

// ===== rtl/two_class_weighted_ticket_queue_unit.sv =====
// two-class ticket queue: tickets wait in arrival order, each flagged
// priority or common
// input channel: push/full queue handshake carrying cmd, ticket_number,
// is_priority and random_draw; a beat is taken when push is high and full low
// result channel: empty/pop; the oldest result sits on the result ports while
// empty is low and leaves on a beat with pop high
// commands: insert appends, remove takes the oldest ticket of the class chosen
// by random_draw < priority_share (oldest ticket of all if that class is
// absent), clear drops everything; every command yields one result beat
// config: APB register 0 at byte address 0 holds priority_share, reset 7
// path: a beat passes the front-end register, command queue and result register
// throughput: one command per cycle while the result register is empty or
// being popped; the cell chain finds, shifts and counts combinationally
// a short two-entry command queue sits between the front end and cell chain
// reset: queue empty, no results pending, share back to 7
// receiver stall: the result register holds, the command queue fills, then
// full rises and the sender waits; nothing is lost
`include "two_class_weighted_ticket_queue_unit_macros.svh"

module two_class_weighted_ticket_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// apb config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// command channel
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    cmd,
	input  logic [twtq_pkg::TICKET_W-1:0] ticket_number,
	input  logic                          is_priority,
	input  logic [3:0]                    random_draw,
	// result channel
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    status,
	output logic [twtq_pkg::TICKET_W-1:0] removed_ticket,
	output logic                          removed_priority,
	output logic [twtq_pkg::COUNT_W-1:0]  entry_count,
	output logic                          queue_empty,
	output logic                          queue_full
);
	import twtq_pkg::*;

	logic [SHARE_W-1:0] share_q;
	op_t                front_op;
	logic               front_valid;
	logic               front_ready;
	op_t                back_op;
	logic               back_valid;
	logic               back_ready;
	result_t            res;
	logic               res_valid;

	// config register, word select on paddr[2], byte bits ignored
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SHARE) ? {{(32-SHARE_W){1'b0}}, share_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			share_q <= SHARE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SHARE)) begin
			share_q <= pwdata[SHARE_W-1:0];
		end
	end

	// front end: takes the beat and picks the wanted class
	twtq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.ticket_number (ticket_number),
		.is_priority   (is_priority),
		.random_draw   (random_draw),
		.share         (share_q),
		.op            (front_op),
		.op_valid      (front_valid),
		.op_ready      (front_ready)
	);

	// decoupling queue between classifier and cell chain
	twtq_opq u_opq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (front_op),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_op    (back_op),
		.out_valid (back_valid),
		.out_ready (back_ready)
	);

	// back end: cell chain, count and result register
	twtq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (back_op),
		.op_valid  (back_valid),
		.op_ready  (back_ready),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	assign empty            = !res_valid;
	assign status           = res.status;
	assign removed_ticket   = res.ticket;
	assign removed_priority = res.prio;
	assign entry_count      = res.count;
	assign queue_empty      = res.empty;
	assign queue_full       = res.full;

	// a refused insert must report a full queue, a failed remove an empty one
	`TWTQ_ASSERT_NOW(a_full_status, !empty && (status == ST_FULL), queue_full, "refused insert without full queue")
	`TWTQ_ASSERT_NOW(a_empty_status, !empty && (status == ST_EMPTY), queue_empty && (removed_ticket == '0), "bad empty remove result")
	// a held result cannot be replaced while the receiver stalls
	`TWTQ_ASSERT_NEXT(a_res_hold, !empty && !pop, $stable(res), "result changed under stall")

endmodule
